// File: sv/cht_pkg.sv
// ============================================================================
// cht_pkg
// Shared types, codes and constants of the chained hash table.
// ============================================================================
package cht_pkg;

    localparam int DEF_MAX_BUCKETS  = 64;
    localparam int DEF_BUCKET_SLOTS = 8;
    localparam int DEF_KEY_BITS     = 32;

    localparam int          CFG_W         = 7;
    localparam logic [6:0]  RESET_BUCKETS = 7'd53;
    localparam int          IN_W          = 32;
    localparam int          VAL_W         = 32;
    localparam int          REM_W         = 4;
    localparam int          TOT_W         = 10;

    // action codes
    localparam logic [2:0] ACT_PUT     = 3'd0;
    localparam logic [2:0] ACT_GET     = 3'd1;
    localparam logic [2:0] ACT_DEL_PAIR = 3'd2;
    localparam logic [2:0] ACT_DEL_KEY = 3'd3;
    localparam logic [2:0] ACT_CLEAR   = 3'd4;

    // status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;       // latch input item, start modulo
        logic mod_step;   // one restoring-division step
        logic fill_load;  // latch bucket fill
        logic rd_issue;   // issue read at scan index
        logic scan_step;  // evaluate read data, move scan index
        logic wr_put;     // write put entry
        logic mv_issue;   // read slot after the hole
        logic mv_write;   // write moved slot into the hole
        logic rm_done;    // finish a removal
        logic clear_fill; // clear-pass step
        logic finish;     // latch result
    } cht_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mod_done;
        logic [2:0] act;
        logic bucket_full;
        logic scan_end;
        logic hit;
        logic mv_end;
        logic clr_end;
    } cht_sts_t;

endpackage

// File: sv/cht_ram.sv
// ============================================================================
// cht_ram
// Generic single-port RAM with registered read.
// ============================================================================
module cht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write or read one word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: sv/cht_datapath.sv
// ============================================================================
// cht_datapath
// Bucket modulo, slot memory, fill table, scan and removal shifting.
// ============================================================================
module cht_datapath
    import cht_pkg::*;
#(
    parameter int MAX_BUCKETS  = DEF_MAX_BUCKETS,
    parameter int BUCKET_SLOTS = DEF_BUCKET_SLOTS,
    parameter int KEY_BITS     = DEF_KEY_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic [2:0]        in_action,
    input  logic [IN_W-1:0]   in_key,
    input  logic [VAL_W-1:0]  in_value,
    input  cht_cmd_t          cmd,
    output cht_sts_t          sts,
    output logic [1:0]        res_status,
    output logic [VAL_W-1:0]  res_found,
    output logic [REM_W-1:0]  res_removed,
    output logic [TOT_W-1:0]  res_total
);
    localparam int BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int SW  = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
    localparam int FW  = $clog2(BUCKET_SLOTS + 1);
    localparam int KW  = (KEY_BITS < IN_W) ? KEY_BITS : IN_W;
    localparam int DEPTH = MAX_BUCKETS * BUCKET_SLOTS;
    localparam int AW  = $clog2(DEPTH);
    localparam int NW  = $clog2(MAX_BUCKETS + 1);
    localparam int CW  = $clog2(KW + 1);
    localparam int TW  = $clog2(DEPTH + 1);
    localparam int EW  = KW + VAL_W;

    logic [CFG_W-1:0] bcount_reg;
    logic [NW-1:0]    bucket_div;
    logic [2:0]       act_reg;
    logic [KW-1:0]    key_reg, quot_reg;
    logic [VAL_W-1:0] val_reg, found_reg;
    logic [NW:0]      rem_reg;
    logic [CW-1:0]    mcnt_reg;
    logic [BW-1:0]    bucket_reg, clr_reg;
    logic [FW-1:0]    fill_reg, idx_reg, hole_reg;
    logic [REM_W-1:0] removed_reg;
    logic [TW-1:0]    total_reg;
    logic             hit_reg;
    logic [1:0]       status_reg;

    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [EW-1:0]    ram_wdata, ram_rdata;
    logic [FW-1:0]    ram_slot;
    logic [NW:0]      rem_sh;
    logic             match_key, match_pair;
    logic             fill_we;
    logic [BW-1:0]    fill_addr;
    logic [FW-1:0]    fill_wdata, fill_rdata;

    // clamp the configured count into 1..MAX_BUCKETS
    always_comb begin
        if (bcount_reg == '0) begin
            bucket_div = NW'(1);
        end else if (32'(bcount_reg) > MAX_BUCKETS) begin
            bucket_div = NW'(MAX_BUCKETS);
        end else begin
            bucket_div = NW'(bcount_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bcount_reg <= RESET_BUCKETS;
        end else if (cfg_we) begin
            bcount_reg <= cfg_wdata;
        end
    end

    // restoring division, one key bit a step
    assign rem_sh = {rem_reg[NW-1:0], quot_reg[KW-1]};
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg  <= in_action;
            key_reg  <= in_key[KW-1:0];
            quot_reg <= in_key[KW-1:0];
            val_reg  <= in_value;
            rem_reg  <= '0;
            mcnt_reg <= '0;
        end else if (cmd.mod_step) begin
            quot_reg <= quot_reg << 1;
            mcnt_reg <= mcnt_reg + 1'b1;
            if (rem_sh >= (NW+1)'(bucket_div)) begin
                rem_reg <= rem_sh - (NW+1)'(bucket_div);
            end else begin
                rem_reg <= rem_sh;
            end
        end
    end

    // slot memory: key and value side by side
    always_comb begin
        ram_we    = 1'b0;
        ram_slot  = idx_reg;
        ram_wdata = {val_reg, key_reg};
        if (cmd.wr_put) begin
            ram_we   = 1'b1;
            ram_slot = fill_reg;
        end else if (cmd.mv_issue) begin
            ram_slot = hole_reg + 1'b1;
        end else if (cmd.mv_write) begin
            ram_we    = 1'b1;
            ram_slot  = hole_reg;
            ram_wdata = ram_rdata;
        end
        ram_addr = AW'(32'(bucket_reg) * BUCKET_SLOTS + 32'(ram_slot[SW-1:0]));
    end

    cht_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_slots (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign match_key  = (ram_rdata[KW-1:0] == key_reg);
    assign match_pair = match_key && (ram_rdata[EW-1:KW] == val_reg);

    // fill table port: clear sweep, fill update, else look up the computed bucket
    always_comb begin
        fill_we    = 1'b0;
        fill_addr  = rem_reg[BW-1:0];
        fill_wdata = '0;
        if (cmd.clear_fill) begin
            fill_we   = 1'b1;
            fill_addr = clr_reg;
        end else if (cmd.wr_put) begin
            fill_we    = 1'b1;
            fill_addr  = bucket_reg;
            fill_wdata = fill_reg + 1'b1;
        end else if (cmd.rm_done) begin
            fill_we    = 1'b1;
            fill_addr  = bucket_reg;
            fill_wdata = fill_reg - 1'b1;
        end
    end

    cht_ram #(.WIDTH(FW), .DEPTH(MAX_BUCKETS)) u_fill (
        .aclk (aclk),
        .we   (fill_we),
        .addr (fill_addr),
        .wdata(fill_wdata),
        .rdata(fill_rdata)
    );

    // scan index and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            clr_reg   <= '0;
        end else begin
            if (cmd.fill_load) begin
                bucket_reg  <= rem_reg[BW-1:0];
                fill_reg    <= fill_rdata;
                idx_reg     <= (act_reg == ACT_GET) ? '0 : fill_rdata - 1'b1;
                removed_reg <= '0;
                hit_reg     <= 1'b0;
                found_reg   <= '0;
                clr_reg     <= '0;
            end
            if (cmd.wr_put) begin
                total_reg <= total_reg + 1'b1;
            end
            if (cmd.scan_step) begin
                hit_reg <= 1'b0;
                if (act_reg == ACT_GET) begin
                    if (match_key) begin
                        found_reg <= ram_rdata[EW-1:KW];
                        hit_reg   <= 1'b1;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end else if ((act_reg == ACT_DEL_PAIR && match_pair) ||
                             (act_reg == ACT_DEL_KEY && match_key)) begin
                    hit_reg  <= 1'b1;
                    hole_reg <= idx_reg;
                end else begin
                    idx_reg <= idx_reg - 1'b1;
                end
            end
            if (cmd.mv_write) begin
                hole_reg <= hole_reg + 1'b1;
            end
            if (cmd.rm_done) begin
                fill_reg    <= fill_reg - 1'b1;
                total_reg   <= total_reg - 1'b1;
                removed_reg <= removed_reg + 1'b1;
                idx_reg     <= idx_reg - 1'b1;
                hit_reg     <= 1'b0;
            end
            if (cmd.clear_fill) begin
                clr_reg   <= clr_reg + 1'b1;
                total_reg <= '0;
            end
        end
    end

    // result fields
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            unique case (act_reg)
                ACT_PUT:  status_reg <= (fill_reg >= FW'(BUCKET_SLOTS)) ? ST_FULL : ST_DONE;
                ACT_GET:  status_reg <= (found_reg != '0 || hit_reg) ? ST_DONE : ST_NOT_FOUND;
                ACT_DEL_PAIR,
                ACT_DEL_KEY: status_reg <= (removed_reg != '0) ? ST_DONE : ST_NOT_FOUND;
                default:  status_reg <= ST_DONE;
            endcase
        end
    end

    assign res_status  = status_reg;
    assign res_found   = found_reg;
    assign res_removed = removed_reg;
    assign res_total   = TOT_W'(total_reg);

    assign sts.mod_done    = (32'(mcnt_reg) == KW);
    assign sts.act         = act_reg;
    assign sts.bucket_full = (fill_reg >= FW'(BUCKET_SLOTS));
    assign sts.scan_end    = (act_reg == ACT_GET) ? (idx_reg >= fill_reg) : (idx_reg == '1);
    assign sts.hit         = hit_reg;
    assign sts.mv_end      = (hole_reg + 1'b1 >= fill_reg);
    assign sts.clr_end     = (32'(clr_reg) == MAX_BUCKETS - 1);
endmodule

// File: sv/cht_ctrl.sv
// ============================================================================
// cht_ctrl
// Sequencer of one item: modulo, scan, removal shifting, result handover.
// ============================================================================
module cht_ctrl
    import cht_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_axis_tvalid,
    output logic     s_axis_tready,
    output logic     m_axis_tvalid,
    input  logic     m_axis_tready,
    input  cht_sts_t sts,
    output cht_cmd_t cmd
);
    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_MOD, S_FILL, S_ACT, S_RD, S_WAIT, S_EVAL,
        S_MV_RD, S_MV_WAIT, S_MV_WR, S_RM, S_CLR, S_FIN, S_OUT
    } state_t;

    state_t state_reg, state_next;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT: begin
                // sweep the fill table to zero after reset
                cmd.clear_fill = 1'b1;
                if (sts.clr_end) state_next = S_IDLE;
            end
            S_IDLE: if (s_axis_tvalid) begin
                cmd.load   = 1'b1;
                state_next = S_MOD;
            end
            S_MOD: begin
                if (sts.mod_done) state_next = S_FILL;
                else cmd.mod_step = 1'b1;
            end
            S_FILL: begin
                cmd.fill_load = 1'b1;
                state_next    = S_ACT;
            end
            S_ACT: begin
                unique case (sts.act)
                    ACT_PUT: begin
                        if (!sts.bucket_full) cmd.wr_put = 1'b1;
                        state_next = S_FIN;
                    end
                    ACT_GET, ACT_DEL_PAIR, ACT_DEL_KEY: state_next = S_RD;
                    ACT_CLEAR: state_next = S_CLR;
                    default: state_next = S_FIN;
                endcase
            end
            S_RD: begin
                if (sts.scan_end || sts.hit) state_next = S_FIN;
                else begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_WAIT;
                end
            end
            S_WAIT: state_next = S_EVAL;
            S_EVAL: begin
                // a get ends on its hit in S_RD; a delete goes on to shift
                cmd.scan_step = 1'b1;
                state_next    = (sts.act == ACT_GET) ? S_RD : S_MV_RD;
            end
            S_MV_RD: begin
                if (!sts.hit) state_next = S_RD;
                else if (sts.mv_end) state_next = S_RM;
                else begin
                    cmd.mv_issue = 1'b1;
                    state_next   = S_MV_WAIT;
                end
            end
            S_MV_WAIT: begin
                cmd.mv_issue = 1'b1;
                state_next   = S_MV_WR;
            end
            S_MV_WR: begin
                cmd.mv_write = 1'b1;
                state_next   = S_MV_RD;
            end
            S_RM: begin
                cmd.rm_done = 1'b1;
                state_next  = (sts.act == ACT_DEL_PAIR) ? S_FIN : S_RD;
            end
            S_CLR: begin
                cmd.clear_fill = 1'b1;
                if (sts.clr_end) state_next = S_FIN;
            end
            S_FIN: begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: if (m_axis_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

// File: sv/chained_hash_table.sv
// ============================================================================
// chained_hash_table
// Keyed multimap with separate chaining in bounded buckets.
//
// channel   dir  payload
// s_axis    in   action, key, value
// m_axis    out  status, found_value, removed, stored_total
// cfg       in   bucket_count
//
// One item at a time: a bit-serial modulo picks the bucket and its fill is
// fetched; a get then scans the bucket slot by slot, a delete scans it too,
// shifts the later slots down over each hit and closes each removal; a clear
// sweeps the fill table. The result is latched and held until m_axis_tready.
// Reset is synchronous, active low, and is followed by a sweep of the fill
// table with s_axis_tready low.
// ============================================================================
module chained_hash_table
    import cht_pkg::*;
#(
    parameter int MAX_BUCKETS  = DEF_MAX_BUCKETS,
    parameter int BUCKET_SLOTS = DEF_BUCKET_SLOTS,
    parameter int KEY_BITS     = DEF_KEY_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // action[2:0], key[34:3], value[66:35]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // status[1:0], found_value[33:2],
                                        // removed[37:34], stored_total[47:38]
);
    cht_cmd_t cmd;
    cht_sts_t sts;
    logic [1:0]       st;
    logic [VAL_W-1:0] fv;
    logic [REM_W-1:0] rm;
    logic [TOT_W-1:0] tot;

    cht_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .sts(sts), .cmd(cmd)
    );

    cht_datapath #(
        .MAX_BUCKETS(MAX_BUCKETS), .BUCKET_SLOTS(BUCKET_SLOTS), .KEY_BITS(KEY_BITS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_action(s_axis_tdata[2:0]), .in_key(s_axis_tdata[34:3]),
        .in_value(s_axis_tdata[66:35]),
        .cmd(cmd), .sts(sts),
        .res_status(st), .res_found(fv), .res_removed(rm), .res_total(tot)
    );

    assign m_axis_tdata = {tot, rm, fv, st};

`ifndef SYNTH
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready) else $error("accept while result held");
    a_removed_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[1:0] == ST_NOT_FOUND |-> m_axis_tdata[37:34] == '0)
        else $error("not found with removals");
`endif
endmodule
